### design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Plain invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`endif

### design/lbp_pkg.sv
package lbp_pkg;
	localparam int POOL_ENTRIES = 16;
	localparam int IDX_W = $clog2(POOL_ENTRIES);
	localparam int OCC_W = $clog2(POOL_ENTRIES + 1);
	localparam int TAG_W = 24;
	localparam int MAX_RESULTS = 16;
	// Memory word: valid, dirty, locked, rank, tag.
	localparam int ENT_W = 3 + IDX_W + TAG_W;

	typedef enum logic [2:0] {
		OP_NEW = 3'd0, OP_READ = 3'd1, OP_WRITE = 3'd2, OP_DROP = 3'd3,
		OP_LOCK = 3'd4, OP_UNLOCK = 3'd5, OP_CLOSE = 3'd6, OP_NONE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0, ST_LOADED = 2'd1, ST_NOT_FOUND = 2'd2, ST_ALL_LOCKED = 2'd3
	} status_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic             locked;
		logic [IDX_W-1:0] rank;
		logic [TAG_W-1:0] tag;
	} entry_t;
endpackage

### design/lbp_ram.sv
module lbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/lru_block_pool_with_pinning_unit.sv
// LRU block pool with pinning. Up to POOL_ENTRIES resident block numbers are
// kept in one synchronous memory, each word holding its tag, dirty mark, lock
// mark and recency rank (0 is least recent). Valid bits live in flip-flops so
// that reset empties the pool at once, with no clearing pass. An item is
// handled by a sequencer that sweeps the memory, one entry a cycle. A lookup
// sweep also finds the least recent unlocked entry and a free slot. A
// decision state follows. An update sweep then rewrites the ranks of every
// resident entry, and an emit state loads the result word. When no rank
// changes (a miss without backing store, a load into a pool that is not
// full, unlock, all locked, a drop or close that finds nothing, or an unused
// code) the update state passes straight on to the emit state. Close takes
// a lookup and an update pass for each entry that leaves, up to sixteen per
// item. The memory's single read port sets the pace of the sweeps. Each
// result word waits in one output register; the decision state of a further
// close pass waits until that register has been emptied, so a stalled
// receiver can stretch the item. The next item is taken once the last word
// of the current one has been delivered. The counter start is accepted only
// while the pool is idle with its output register empty, and it wins over an
// input word offered in the same cycle. An eviction that finds every entry
// locked leaves the pool unchanged and reports the all-locked status.
module lru_block_pool_with_pinning_unit
	import lbp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TAG_W-1:0] first_new_block,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       operation,
	input  logic [TAG_W-1:0] block_number,
	input  logic             in_backing_store,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [TAG_W-1:0] assigned_block,
	output logic             victim_valid,
	output logic [TAG_W-1:0] victim_block,
	output logic             victim_write_back,
	output logic             last_result
);
	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_UPDATE, S_EMIT
	} state_t;

	// What the update sweep does to the ranks of the other entries.
	typedef enum logic [1:0] {
		U_NONE, U_TOUCH, U_REMOVE, U_ROTATE
	} upd_t;

	state_t state_q;
	op_t op_q;
	logic [TAG_W-1:0] tag_q, next_blk_q;
	logic backed_q;
	logic [POOL_ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0] occ_q;
	logic [IDX_W:0] cnt_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic rd_live_q;
	logic hit_q, cand_q, free_found_q;
	logic [IDX_W-1:0] hit_idx_q, cand_idx_q, free_idx_q, lru_idx_q;
	logic lru_found_q;
	entry_t hit_ent_q, cand_ent_q, lru_ent_q;
	upd_t upd_q;
	logic [IDX_W-1:0] upd_idx_q, upd_rank_q;
	logic ins_q;
	entry_t ins_ent_q;
	logic [IDX_W-1:0] ins_idx_q;
	logic [4:0] nres_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;

	lbp_ram #(.WIDTH(ENT_W), .DEPTH(POOL_ENTRIES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = (state_q == S_IDLE) && !out_valid;
	assign in_ready = (state_q == S_IDLE) && !out_valid && !cfg_valid;
	assign ram_raddr = cnt_q[IDX_W-1:0];

	// Rank rewrite of the entry arriving from memory during the update sweep, and the entry write of the emit state.
	entry_t cur;
	logic [IDX_W-1:0] top;
	always_comb begin
		cur = ram_rdata;
		cur.valid = valid_q[rd_idx_q];
		top = IDX_W'(occ_q - OCC_W'(1));
		ram_we = 1'b0;
		ram_waddr = rd_idx_q;
		ram_wdata = cur;
		if (state_q == S_UPDATE && rd_live_q && cur.valid) begin
			ram_we = 1'b1;
			if (rd_idx_q == upd_idx_q) begin
				ram_wdata.rank = top;
				if (op_q == OP_WRITE) ram_wdata.dirty = 1'b1;
				if (op_q == OP_LOCK) ram_wdata.locked = 1'b1;
			end else begin
				unique case (upd_q)
					U_TOUCH, U_REMOVE: begin
						if (cur.rank > upd_rank_q) ram_wdata.rank = cur.rank - 1'b1;
					end
					U_ROTATE: begin
						if (cur.rank > upd_rank_q) ram_wdata.rank = cur.rank - upd_rank_q - 1'b1;
						else ram_wdata.rank = cur.rank + (top - upd_rank_q);
					end
					default: ram_we = 1'b0;
				endcase
			end
		end else if (state_q == S_EMIT && ins_q) begin
			ram_we = 1'b1;
			ram_waddr = ins_idx_q;
			ram_wdata = ins_ent_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			occ_q <= '0;
			next_blk_q <= '0;
			out_valid <= 1'b0;
			cnt_q <= '0;
			rd_live_q <= 1'b0;
			ins_q <= 1'b0;
			nres_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			rd_live_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) next_blk_q <= first_new_block;
					if (in_valid && in_ready) begin
						op_q <= op_t'(operation);
						tag_q <= (op_t'(operation) == OP_NEW) ? next_blk_q : block_number;
						backed_q <= in_backing_store;
						nres_q <= '0;
						cnt_q <= '0;
						hit_q <= 1'b0; cand_q <= 1'b0; free_found_q <= 1'b0;
						lru_found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// One entry read per cycle; each result is checked in the cycle after its read.
					if (cnt_q < (IDX_W+1)'(POOL_ENTRIES)) begin
						rd_idx_q <= cnt_q[IDX_W-1:0];
						rd_live_q <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_live_q) begin
						if (cur.valid && cur.tag == tag_q && !hit_q) begin
							hit_q <= 1'b1; hit_idx_q <= rd_idx_q; hit_ent_q <= cur;
						end
						if (cur.valid && !cur.locked &&
						    (!cand_q || cur.rank < cand_ent_q.rank)) begin
							cand_q <= 1'b1; cand_idx_q <= rd_idx_q; cand_ent_q <= cur;
						end
						if (cur.valid && cur.rank == '0) begin
							lru_found_q <= 1'b1; lru_idx_q <= rd_idx_q; lru_ent_q <= cur;
						end
						if (!cur.valid && !free_found_q) begin
							free_found_q <= 1'b1; free_idx_q <= rd_idx_q;
						end
					end else if (cnt_q == (IDX_W+1)'(POOL_ENTRIES)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					// The output register may still hold the previous word of a close.
					if (!out_valid) begin
						status <= ST_DONE;
						assigned_block <= '0;
						victim_valid <= 1'b0;
						victim_block <= '0;
						victim_write_back <= 1'b0;
						upd_q <= U_NONE;
						ins_q <= 1'b0;
						last_result <= 1'b1;
						state_q <= S_UPDATE;
						case (op_q)
							OP_NEW, OP_READ, OP_WRITE, OP_LOCK: begin
								if (hit_q) begin
									upd_q <= U_TOUCH; upd_idx_q <= hit_idx_q;
									upd_rank_q <= hit_ent_q.rank;
									if (op_q == OP_NEW) begin
										assigned_block <= tag_q;
										next_blk_q <= next_blk_q + 1'b1;
									end
								end else if (op_q != OP_NEW && !backed_q) begin
									status <= ST_NOT_FOUND;
								end else if (occ_q == OCC_W'(POOL_ENTRIES) && !cand_q) begin
									status <= ST_ALL_LOCKED;
								end else begin
									if (op_q == OP_NEW) begin
										assigned_block <= tag_q;
										next_blk_q <= next_blk_q + 1'b1;
									end else begin
										status <= ST_LOADED;
									end
									ins_q <= 1'b1;
									ins_ent_q.dirty <= (op_q == OP_WRITE);
									ins_ent_q.locked <= (op_q == OP_LOCK);
									ins_ent_q.tag <= tag_q;
									ins_ent_q.valid <= 1'b1;
									if (occ_q == OCC_W'(POOL_ENTRIES)) begin
										victim_valid <= 1'b1;
										victim_block <= cand_ent_q.tag;
										victim_write_back <= cand_ent_q.dirty;
										upd_q <= U_ROTATE; upd_idx_q <= cand_idx_q;
										upd_rank_q <= cand_ent_q.rank;
										ins_idx_q <= cand_idx_q;
										ins_ent_q.rank <= IDX_W'(occ_q - OCC_W'(1));
										valid_q[cand_idx_q] <= 1'b0;
									end else begin
										ins_idx_q <= free_idx_q;
										ins_ent_q.rank <= IDX_W'(occ_q);
										occ_q <= occ_q + 1'b1;
									end
								end
							end
							OP_DROP: begin
								if (hit_q) begin
									victim_valid <= 1'b1;
									victim_block <= tag_q;
									upd_q <= U_REMOVE; upd_idx_q <= hit_idx_q;
									upd_rank_q <= hit_ent_q.rank;
									valid_q[hit_idx_q] <= 1'b0;
									occ_q <= occ_q - 1'b1;
								end
							end
							OP_UNLOCK: begin
								if (hit_q) begin
									ins_q <= 1'b1; ins_idx_q <= hit_idx_q;
									ins_ent_q <= '{valid: 1'b1, dirty: hit_ent_q.dirty,
										locked: 1'b0, rank: hit_ent_q.rank,
										tag: hit_ent_q.tag};
								end else begin
									status <= ST_NOT_FOUND;
								end
							end
							OP_CLOSE: begin
								if (lru_found_q) begin
									victim_valid <= 1'b1;
									victim_block <= lru_ent_q.tag;
									victim_write_back <= lru_ent_q.dirty;
									upd_q <= U_REMOVE; upd_idx_q <= lru_idx_q;
									upd_rank_q <= '0;
									valid_q[lru_idx_q] <= 1'b0;
									occ_q <= occ_q - 1'b1;
									last_result <= (occ_q == OCC_W'(1)) ||
										(nres_q == 5'(MAX_RESULTS - 1));
								end
							end
							default: ;
						endcase
						cnt_q <= '0;
					end
				end
				S_UPDATE: begin
					// Removed entries were cleared in valid_q, so they are skipped.
					if (upd_q == U_NONE) begin
						state_q <= S_EMIT;
					end else begin
						if (cnt_q < (IDX_W+1)'(POOL_ENTRIES)) begin
							rd_idx_q <= cnt_q[IDX_W-1:0];
							rd_live_q <= 1'b1;
							cnt_q <= cnt_q + 1'b1;
						end else if (!rd_live_q) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (!out_valid) begin
						if (ins_q) valid_q[ins_idx_q] <= 1'b1;
						ins_q <= 1'b0;
						out_valid <= 1'b1;
						nres_q <= nres_q + 1'b1;
						cnt_q <= '0;
						hit_q <= 1'b0; cand_q <= 1'b0; free_found_q <= 1'b0;
						lru_found_q <= 1'b0;
						state_q <= last_result ? S_IDLE : S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/lbp_checker.sv
`include "assert_macros.svh"
module lbp_checker
	import lbp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             cfg_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       status,
	input logic [TAG_W-1:0] victim_block,
	input logic             victim_valid,
	input logic             victim_write_back,
	input logic             last_result
);
	`ASSERT_IMPL(a_out_hold, clk, arst_n, out_valid && !out_ready, ##1 out_valid)
	`ASSERT_IMPL(a_busy_no_in, clk, arst_n, out_valid, !in_ready)
	`ASSERT_IMPL(a_no_victim_fields, clk, arst_n, out_valid && !victim_valid,
		victim_block == '0 && !victim_write_back)
	`ASSERT_IMPL(a_locked_no_victim, clk, arst_n, out_valid && status == ST_ALL_LOCKED,
		!victim_valid && last_result)
	`ASSERT_ALWAYS(a_cfg_idle, clk, arst_n, !in_ready || cfg_ready)
endmodule

bind lru_block_pool_with_pinning_unit lbp_checker u_lbp_checker (.*);

### dv/lru_block_pool_with_pinning_unit_tb.sv
`timescale 1ns / 1ps

module lru_block_pool_with_pinning_unit_tb;
	import lbp_pkg::*;

	typedef struct {
		logic [1:0]       status;
		logic [TAG_W-1:0] assigned;
		logic             vic_valid;
		logic [TAG_W-1:0] vic_block;
		logic             vic_wb;
		logic             last;
	} pool_word_t;

	// Scoreboard: a private copy of the pool, updated as each input word is
	// accepted, and a queue of the result words that the pool should return.
	class pool_scoreboard;
		logic [TAG_W-1:0] tag[POOL_ENTRIES];
		bit               used[POOL_ENTRIES];
		bit               dirty[POOL_ENTRIES];
		bit               pinned[POOL_ENTRIES];
		int unsigned      rank[POOL_ENTRIES];
		int unsigned      occ;
		logic [TAG_W-1:0] next_blk;
		pool_word_t       pending[$];
		int               errors;

		function void set_counter(logic [TAG_W-1:0] v);
			next_blk = v;
		endfunction

		function void push(logic [1:0] st, logic [TAG_W-1:0] asg, bit vv,
				logic [TAG_W-1:0] vb, bit vw, bit lst);
			pool_word_t w;
			w.status = st; w.assigned = asg; w.vic_valid = vv;
			w.vic_block = vb; w.vic_wb = vw; w.last = lst;
			pending.insert(pending.size(), w);
		endfunction

		function int find(logic [TAG_W-1:0] t);
			for (int i = 0; i < POOL_ENTRIES; i++)
				if (used[i] && tag[i] == t) return i;
			return -1;
		endfunction

		function void touch(int e);
			for (int i = 0; i < POOL_ENTRIES; i++)
				if (used[i] && rank[i] > rank[e]) rank[i]--;
			rank[e] = occ - 1;
		endfunction

		function void remove(int e);
			for (int i = 0; i < POOL_ENTRIES; i++)
				if (used[i] && rank[i] > rank[e]) rank[i]--;
			used[e] = 0; dirty[e] = 0; pinned[e] = 0;
			occ--;
		endfunction

		// Evicts the least recent unpinned entry when full; pinned entries
		// below it rotate to the top. Returns 0 when every entry is pinned.
		function bit make_room(output bit vv, output logic [TAG_W-1:0] vb,
				output bit vw);
			int v;
			int unsigned rv;
			int unsigned top;
			v = -1; vv = 0; vb = '0; vw = 0;
			if (occ < POOL_ENTRIES) return 1;
			for (int i = 0; i < POOL_ENTRIES; i++)
				if (used[i] && !pinned[i] && (v < 0 || rank[i] < rank[v])) v = i;
			if (v < 0) return 0;
			rv = rank[v];
			top = occ - 1;
			vv = 1; vb = tag[v]; vw = dirty[v];
			for (int i = 0; i < POOL_ENTRIES; i++) begin
				if (!used[i] || i == v) continue;
				if (rank[i] > rv) rank[i] -= rv + 1;
				else rank[i] += top - rv;
			end
			used[v] = 0; dirty[v] = 0; pinned[v] = 0;
			occ--;
			return 1;
		endfunction

		function void insert(logic [TAG_W-1:0] t, bit d, bit p);
			for (int i = 0; i < POOL_ENTRIES; i++)
				if (!used[i]) begin
					used[i] = 1; tag[i] = t; dirty[i] = d; pinned[i] = p;
					rank[i] = occ;
					occ++;
					return;
				end
		endfunction

		function void note(logic [2:0] op, logic [TAG_W-1:0] blk, bit backed);
			int e;
			int n;
			logic [1:0] st;
			logic [TAG_W-1:0] asg;
			bit vv;
			bit vw;
			logic [TAG_W-1:0] vb;
			st = ST_DONE; asg = '0; vv = 0; vb = '0; vw = 0;
			case (op)
				OP_CLOSE: begin
					n = 0;
					while (occ > 0 && n < MAX_RESULTS) begin
						e = -1;
						for (int i = 0; i < POOL_ENTRIES; i++)
							if (used[i] && rank[i] == 0) e = i;
						if (e < 0) break;
						push(ST_DONE, '0, 1, tag[e], dirty[e], 0);
						remove(e);
						n++;
					end
					if (n == 0) push(ST_DONE, '0, 0, '0, 0, 1);
					else pending[pending.size() - 1].last = 1;
					return;
				end
				OP_NEW: begin
					e = find(next_blk);
					if (e >= 0) begin
						touch(e);
						asg = next_blk;
						next_blk = next_blk + 1'b1;
					end else if (make_room(vv, vb, vw)) begin
						insert(next_blk, 0, 0);
						asg = next_blk;
						next_blk = next_blk + 1'b1;
					end else st = ST_ALL_LOCKED;
				end
				OP_READ, OP_WRITE, OP_LOCK: begin
					e = find(blk);
					if (e >= 0) begin
						if (op == OP_WRITE) dirty[e] = 1;
						if (op == OP_LOCK) pinned[e] = 1;
						touch(e);
					end else if (!backed) st = ST_NOT_FOUND;
					else if (make_room(vv, vb, vw)) begin
						insert(blk, op == OP_WRITE, op == OP_LOCK);
						st = ST_LOADED;
					end else st = ST_ALL_LOCKED;
				end
				OP_DROP: begin
					e = find(blk);
					if (e >= 0) begin
						vv = 1; vb = blk;
						remove(e);
					end
				end
				OP_UNLOCK: begin
					e = find(blk);
					if (e >= 0) pinned[e] = 0;
					else st = ST_NOT_FOUND;
				end
				default: ;
			endcase
			push(st, asg, vv, vb, vw, 1);
		endfunction

		function void check(pool_word_t got);
			pool_word_t exp_w;
			if (pending.size() == 0) begin
				$display("%0t: result word with nothing expected", $realtime);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.status !== exp_w.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime,
					exp_w.status, got.status);
				errors++;
			end
			if (got.assigned !== exp_w.assigned) begin
				$display("%0t: assigned_block expected %h actual %h", $realtime,
					exp_w.assigned, got.assigned);
				errors++;
			end
			if (got.vic_valid !== exp_w.vic_valid) begin
				$display("%0t: victim_valid expected %0d actual %0d", $realtime,
					exp_w.vic_valid, got.vic_valid);
				errors++;
			end
			if (got.vic_block !== exp_w.vic_block) begin
				$display("%0t: victim_block expected %h actual %h", $realtime,
					exp_w.vic_block, got.vic_block);
				errors++;
			end
			if (got.vic_wb !== exp_w.vic_wb) begin
				$display("%0t: victim_write_back expected %0d actual %0d", $realtime,
					exp_w.vic_wb, got.vic_wb);
				errors++;
			end
			if (got.last !== exp_w.last) begin
				$display("%0t: last_result expected %0d actual %0d", $realtime,
					exp_w.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [TAG_W-1:0] first_new_block;
	logic             in_valid;
	logic             in_ready;
	logic [2:0]       operation;
	logic [TAG_W-1:0] block_number;
	logic             in_backing_store;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [TAG_W-1:0] assigned_block;
	logic             victim_valid;
	logic [TAG_W-1:0] victim_block;
	logic             victim_write_back;
	logic             last_result;

	pool_scoreboard pool_sb = new();

	// When set, neither side idles; used for the closing stretch of the run.
	bit quiet;
	// Number of cycles the receiver is asked to hold off in one stretch.
	int hold_request;

	lru_block_pool_with_pinning_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.first_new_block   (first_new_block),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.operation         (operation),
		.block_number      (block_number),
		.in_backing_store  (in_backing_store),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.assigned_block    (assigned_block),
		.victim_valid      (victim_valid),
		.victim_block      (victim_block),
		.victim_write_back (victim_write_back),
		.last_result       (last_result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver. It stalls in short random bursts, and once in the run it holds
	// off for a long stretch so that the pool fills its output register and
	// stops taking input words.
	int stall_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_request > 0 && !hold_done) begin
			stall_left <= hold_request;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every result word taken at a clock edge is checked against the oldest
	// expectation. Values are read as they stood before the edge.
	always @(posedge clk) begin
		pool_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.assigned = assigned_block;
			got.vic_valid = victim_valid;
			got.vic_block = victim_block;
			got.vic_wb = victim_write_back;
			got.last = last_result;
			pool_sb.check(got);
		end
	end

	// Offers one input word and waits until the pool accepts it. Valid is
	// left high afterwards, so back-to-back words need no gap.
	task automatic send_word(logic [2:0] op, logic [TAG_W-1:0] blk, bit backed);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		block_number <= blk;
		in_backing_store <= backed;
		do @(posedge clk); while (!in_ready);
		pool_sb.note(op, blk, backed);
	endtask

	// Stops offering and waits until every expected word has come back.
	task automatic drain_pool();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pool_sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Writes the start of the new-block counter; the pool is idle here.
	task automatic load_counter(logic [TAG_W-1:0] v);
		cfg_valid <= 1'b1;
		first_new_block <= v;
		do @(posedge clk); while (!cfg_ready);
		pool_sb.set_counter(v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Pins sixteen blocks, then asks for one more load, which must report that every entry is pinned,
	// and for a new block whose number is resident. An unlock and a write follow; a close clears it all.
	task automatic pin_everything(logic [TAG_W-1:0] base);
		for (int i = 0; i < POOL_ENTRIES; i++)
			send_word(OP_LOCK, TAG_W'(base + i), 1'b1);
		send_word(OP_READ, TAG_W'(base + POOL_ENTRIES), 1'b1);
		send_word(OP_NEW, '0, 1'b0);
		send_word(OP_UNLOCK, TAG_W'(base + 3), 1'b0);
		send_word(OP_WRITE, TAG_W'(base + 40), 1'b1);
		send_word(OP_CLOSE, '0, 1'b0);
		send_word(OP_CLOSE, '0, 1'b0);
	endtask

	// Random words. Most address a small set of blocks near the counter, so
	// that hits, evictions and clashes with new numbers are common; a few use
	// the whole block number range.
	task automatic random_words(int count, logic [TAG_W-1:0] base);
		int pick;
		logic [2:0] op;
		logic [TAG_W-1:0] blk;
		bit backed;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) op = OP_NEW;
			else if (pick < 36) op = OP_READ;
			else if (pick < 54) op = OP_WRITE;
			else if (pick < 64) op = OP_DROP;
			else if (pick < 75) op = OP_LOCK;
			else if (pick < 91) op = OP_UNLOCK;
			else if (pick < 95) op = OP_CLOSE;
			else op = OP_NONE;
			if ($urandom_range(0, 6) == 0) blk = TAG_W'($urandom);
			else blk = TAG_W'(base + $urandom_range(0, 23));
			backed = ($urandom_range(0, 4) != 0);
			send_word(op, blk, backed);
		end
	endtask

	initial begin
		quiet = 0;
		hold_request = 0;
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		first_new_block <= '0;
		in_valid <= 1'b0;
		operation <= OP_NONE;
		block_number <= '0;
		in_backing_store <= 1'b0;
		pool_sb.errors = 0;
		pool_sb.occ = 0;
		pool_sb.next_blk = '0;
		for (int i = 0; i < POOL_ENTRIES; i++) begin
			pool_sb.used[i] = 0;
			pool_sb.dirty[i] = 0;
			pool_sb.pinned[i] = 0;
			pool_sb.rank[i] = 0;
			pool_sb.tag[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: each operation, hits and misses with and without the
		// backing store, the field extremes, the unused code and an empty close.
		send_word(OP_NEW, '0, 1'b0);
		send_word(OP_NEW, '1, 1'b1);
		send_word(OP_READ, '0, 1'b0);
		send_word(OP_READ, '1, 1'b0);
		send_word(OP_READ, '1, 1'b1);
		send_word(OP_WRITE, 24'd5, 1'b1);
		send_word(OP_WRITE, '0, 1'b0);
		send_word(OP_LOCK, 24'd7, 1'b1);
		send_word(OP_LOCK, 24'd1, 1'b0);
		send_word(OP_UNLOCK, 24'd7, 1'b0);
		send_word(OP_UNLOCK, 24'h123, 1'b1);
		send_word(OP_DROP, 24'd5, 1'b0);
		send_word(OP_DROP, 24'h999, 1'b0);
		send_word(OP_LOCK, 24'd9, 1'b0);
		send_word(OP_NONE, 24'hA5A5A5, 1'b1);
		send_word(OP_CLOSE, '0, 1'b0);
		send_word(OP_CLOSE, '0, 1'b0);
		drain_pool();

		// Counter near the top so that it wraps, and clashes with residents.
		load_counter(24'hFFFFF8);
		pin_everything(24'hFFFFF0);
		random_words(60, 24'hFFFFF4);

		// The sender keeps offering while the receiver holds off for a while.
		hold_request = 300;
		random_words(20, 24'hFFFFF4);
		drain_pool();

		load_counter('0);
		random_words(60, '0);
		drain_pool();

		load_counter(TAG_W'($urandom));
		random_words(60, pool_sb.next_blk);
		drain_pool();

		load_counter('1);
		quiet = 1;
		random_words(40, 24'hFFFFF0);
		in_valid <= 1'b0;

		while (pool_sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (pool_sb.errors == 0 && pool_sb.pending.size() == 0) begin
			$display("lru_block_pool_with_pinning_unit_tb: clean");
		end else begin
			$display("lru_block_pool_with_pinning_unit_tb: errors");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("lru_block_pool_with_pinning_unit_tb: errors");
		$finish;
	end

endmodule
